### design/atcs_pkg.sv
// Shared types, constants and helper functions for the ANSI text console stream core.
package atcs_pkg;

    localparam int ARG_SLOTS   = 4;
    localparam int MAX_RESULTS = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W      = $clog2(MAX_RESULTS);
    localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int CFG_IDX_W   = 2;

    // command kinds
    localparam logic [1:0] CMD_DRAW   = 2'd0;
    localparam logic [1:0] CMD_SCROLL = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS    = 2'd1;

    // action codes
    localparam logic ACT_CHAR  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // byte codes
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_LBRK = 8'h5B;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_SGR  = 8'h6D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // SGR command and selector values
    localparam logic [15:0] SGR_FG      = 16'd38;
    localparam logic [15:0] SGR_BG      = 16'd48;
    localparam logic [15:0] SEL_PALETTE = 16'd5;
    localparam logic [15:0] SEL_DIRECT  = 16'd2;

    localparam logic [3:0]  POS_MAX     = 4'd15;
    localparam logic [23:0] FG_RESET    = 24'hFFFFFF;
    localparam logic [23:0] BG_RESET    = 24'h000000;
    localparam logic [9:0]  COLS_RESET  = 10'd80;
    localparam logic [9:0]  ROWS_RESET  = 10'd25;

    typedef struct packed {
        logic        action;
        logic [7:0]  char_code;
        logic [23:0] clear_color;
    } item_t;

    typedef struct packed {
        logic [1:0]  command_kind;
        logic [9:0]  text_col;
        logic [9:0]  text_row;
        logic [7:0]  glyph_code;
        logic [23:0] fg_color;
        logic [23:0] bg_color;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [9:0] cols;
        logic [9:0] rows;
    } geom_t;

    typedef struct packed {
        logic [9:0] col;
        logic [9:0] row;
    } cursor_t;

    typedef struct packed {
        cursor_t cur;
        logic    scroll;
    } step_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] col;
        logic [9:0] row;
        logic [7:0] glyph;
    } slot_t;

    // all commands of one item; fg/bg are the same for every command of it
    typedef struct packed {
        logic [RCNT_W-1:0]            count;
        logic [23:0]                  fg;
        logic [23:0]                  bg;
        slot_t [MAX_RESULTS-1:0]      slots;
    } bundle_t;

    function automatic logic [23:0] palette_f(logic [3:0] idx);
        logic [23:0] c;
        unique case (idx)
            4'd0:    c = 24'h000000;
            4'd1:    c = 24'hAA0000;
            4'd2:    c = 24'h00AA00;
            4'd3:    c = 24'hAAAA00;
            4'd4:    c = 24'h0000AA;
            4'd5:    c = 24'hAA00AA;
            4'd6:    c = 24'h00AAAA;
            4'd7:    c = 24'hAAAAAA;
            4'd8:    c = 24'h555555;
            4'd9:    c = 24'hFF5555;
            4'd10:   c = 24'h55FF55;
            4'd11:   c = 24'hFFFF55;
            4'd12:   c = 24'h5555FF;
            4'd13:   c = 24'hFF55FF;
            4'd14:   c = 24'h55FFFF;
            default: c = 24'hFFFFFF;
        endcase
        return c;
    endfunction

    // a*10 + d, wrapping at 16 bits
    function automatic logic [15:0] acc_digit(logic [15:0] a, logic [3:0] d);
        return (a << 3) + (a << 1) + {12'd0, d};
    endfunction

endpackage

### design/atcs_front.sv
// Front end: accepts items, parses escape sequences, tracks cursor and colors, builds command bundles.
module atcs_front
    import atcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  geom_t   geom,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    input  logic    q_full,
    output logic    push,
    output bundle_t bundle
);

    logic [9:0]  col_reg, col_next;
    logic [9:0]  row_reg, row_next;
    logic        esc_reg, esc_next;
    logic        seq_reg, seq_next;
    logic [3:0]  pos_reg, pos_next;
    logic [15:0] cmd_reg, cmd_next;
    logic [15:0] arg_reg  [ARG_SLOTS];
    logic [15:0] arg_next [ARG_SLOTS];
    logic [23:0] fg_reg, fg_next;
    logic [23:0] bg_reg, bg_next;

    logic accept;

    function automatic step_t newline_f(cursor_t c, geom_t g);
        step_t      s;
        logic [9:0] r1;
        r1       = c.row + 10'd1;
        s.scroll = (r1 >= g.rows);
        s.cur.col = '0;
        if (s.scroll)
            s.cur.row = (g.rows == 10'd0) ? 10'd0 : g.rows - 10'd1;
        else
            s.cur.row = r1;
        return s;
    endfunction

    function automatic step_t advance_f(cursor_t c, geom_t g);
        step_t      s;
        cursor_t    t;
        t.col = c.col + 10'd1;
        t.row = c.row;
        if (t.col >= g.cols) begin
            s = newline_f(t, g);
        end
        else begin
            s.cur    = t;
            s.scroll = 1'b0;
        end
        return s;
    endfunction

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    always_comb begin
        cursor_t           cur;
        step_t             s;
        logic [RCNT_W-1:0] n;
        logic [7:0]        c;
        logic              do_esc_glyph;
        logic              do_plain;
        logic [3:0]        d;
        logic [23:0]       colour;
        logic              colour_ok;

        c        = item.char_code;
        d        = c[3:0] - CH_ZERO[3:0];
        cur.col  = col_reg;
        cur.row  = row_reg;
        s        = '0;
        n        = '0;
        bundle   = '0;
        colour   = '0;
        colour_ok = 1'b0;
        esc_next = esc_reg;
        seq_next = seq_reg;
        pos_next = pos_reg;
        cmd_next = cmd_reg;
        for (int i = 0; i < ARG_SLOTS; i++)
            arg_next[i] = arg_reg[i];
        fg_next  = fg_reg;
        bg_next  = bg_reg;
        do_esc_glyph = 1'b0;
        do_plain     = 1'b0;
        bundle.fg = fg_reg;
        bundle.bg = bg_reg;

        if (item.action == ACT_CLEAR) begin
            esc_next = 1'b0;
            seq_next = 1'b0;
            cur      = '0;
            bundle.slots[0].kind = CMD_CLEAR;
            bundle.bg = item.clear_color;
            n = RCNT_W'(1);
        end
        else if (seq_reg) begin
            priority if (c == CH_SEMI) begin
                if (pos_reg < POS_MAX)
                    pos_next = pos_reg + 4'd1;
            end
            else if (c == CH_SGR) begin
                seq_next = 1'b0;
                if (arg_reg[0] == SEL_PALETTE) begin
                    colour    = palette_f(arg_reg[1][3:0]);
                    colour_ok = 1'b1;
                end
                else if (arg_reg[0] == SEL_DIRECT) begin
                    colour    = {arg_reg[1][7:0], arg_reg[2][7:0], arg_reg[3][7:0]};
                    colour_ok = 1'b1;
                end
                if (colour_ok && cmd_reg == SGR_FG)
                    fg_next = colour;
                else if (colour_ok && cmd_reg == SGR_BG)
                    bg_next = colour;
            end
            else if (c >= CH_ZERO && c <= CH_NINE) begin
                if (pos_reg == 4'd0)
                    cmd_next = acc_digit(cmd_reg, d);
                for (int i = 0; i < ARG_SLOTS; i++)
                    if (pos_reg != 4'd0 && (pos_reg - 4'd1) == 4'(i))
                        arg_next[i] = acc_digit(arg_reg[i], d);
            end
            else begin
                // any other byte inside a sequence is dropped
            end
        end
        else if (esc_reg) begin
            esc_next = 1'b0;
            if (c == CH_LBRK) begin
                seq_next = 1'b1;
                pos_next = '0;
                cmd_next = '0;
                for (int i = 0; i < ARG_SLOTS; i++)
                    arg_next[i] = '0;
            end
            else begin
                do_esc_glyph = 1'b1;
                do_plain     = 1'b1;
            end
        end
        else begin
            do_plain = 1'b1;
        end

        // lone ESC is drawn as a glyph before the byte after it
        if (do_esc_glyph) begin
            bundle.slots[n[SLOT_W-1:0]] = '{CMD_DRAW, cur.col, cur.row, CH_ESC};
            n = n + RCNT_W'(1);
            s = advance_f(cur, geom);
            cur = s.cur;
            if (s.scroll) begin
                bundle.slots[n[SLOT_W-1:0]] = '{CMD_SCROLL, 10'd0, 10'd0, 8'd0};
                n = n + RCNT_W'(1);
            end
        end

        if (do_plain) begin
            priority if (c == CH_LF) begin
                s = newline_f(cur, geom);
                cur = s.cur;
                if (s.scroll) begin
                    bundle.slots[n[SLOT_W-1:0]] = '{CMD_SCROLL, 10'd0, 10'd0, 8'd0};
                    n = n + RCNT_W'(1);
                end
            end
            else if (c == CH_CR) begin
                cur.col = '0;
            end
            else if (c == CH_ESC) begin
                esc_next = 1'b1;
            end
            else if (c != CH_NUL) begin
                bundle.slots[n[SLOT_W-1:0]] = '{CMD_DRAW, cur.col, cur.row, c};
                n = n + RCNT_W'(1);
                s = advance_f(cur, geom);
                cur = s.cur;
                if (s.scroll) begin
                    bundle.slots[n[SLOT_W-1:0]] = '{CMD_SCROLL, 10'd0, 10'd0, 8'd0};
                    n = n + RCNT_W'(1);
                end
            end
            else begin
                // NUL
            end
        end

        col_next     = cur.col;
        row_next     = cur.row;
        bundle.count = n;
        push         = accept && (n != '0);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            col_reg <= '0;
            row_reg <= '0;
            esc_reg <= 1'b0;
            seq_reg <= 1'b0;
            pos_reg <= '0;
            cmd_reg <= '0;
            for (int i = 0; i < ARG_SLOTS; i++)
                arg_reg[i] <= '0;
            fg_reg  <= FG_RESET;
            bg_reg  <= BG_RESET;
        end
        else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
            esc_reg <= esc_next;
            seq_reg <= seq_next;
            pos_reg <= pos_next;
            cmd_reg <= cmd_next;
            for (int i = 0; i < ARG_SLOTS; i++)
                arg_reg[i] <= arg_next[i];
            fg_reg  <= fg_next;
            bg_reg  <= bg_next;
        end
    end

endmodule

### design/atcs_queue.sv
// Short bundle queue between the front end and the command sequencer.
module atcs_queue
    import atcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t wdata,
    input  logic    pop,
    output bundle_t rdata,
    output logic    empty,
    output logic    full
);

    bundle_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg, rptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign rdata = mem[rptr_reg];

    always_ff @(posedge clk) begin
        if (push)
            mem[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else begin
            if (push)
                wptr_reg <= (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue push while full");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> !empty)
        else $error("pushed bundle lost");

endmodule

### design/atcs_back.sv
// Command sequencer: pops bundles, plays commands one per cycle if unstalled.
module atcs_back
    import atcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  bundle_t q_head,
    output logic    pop,
    output logic    cmd_valid,
    input  logic    cmd_stall,
    output result_t cmd
);

    bundle_t           cur_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic              busy_reg;
    logic              at_last;
    logic              take;
    slot_t             slot;

    assign slot      = cur_reg.slots[idx_reg];
    assign at_last   = ({1'b0, idx_reg} == (cur_reg.count - RCNT_W'(1)));
    assign take      = busy_reg && !cmd_stall;
    assign pop       = !q_empty && (!busy_reg || (take && at_last));
    assign cmd_valid = busy_reg;

    always_comb begin
        cmd.command_kind = slot.kind;
        cmd.text_col     = slot.col;
        cmd.text_row     = slot.row;
        cmd.glyph_code   = slot.glyph;
        cmd.fg_color     = cur_reg.fg;
        cmd.bg_color     = cur_reg.bg;
        cmd.last         = at_last;
    end

    always_ff @(posedge clk) begin
        if (pop)
            cur_reg <= q_head;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (pop) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (take && at_last) begin
            busy_reg <= 1'b0;
        end
        else if (take) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> (cur_reg.count != '0))
        else $error("empty bundle in sequencer");
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> ({1'b0, idx_reg} < cur_reg.count))
        else $error("slot index beyond bundle");
    a_burst_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && !cmd.last) |=> cmd_valid)
        else $error("burst ended before last command");

endmodule

### design/ansi_text_console_stream_core.sv
// Top level of the ANSI text console stream core: config registers, front end, queue, sequencer.
//
// Usage:
//   item channel (item_valid / item_stall / item): one console byte or a clear
//   request per item. The item is taken at a clock edge with item_valid high and
//   item_stall low. item_stall rises only while the bundle queue is full.
//   cmd channel (cmd_valid / cmd_stall / cmd): draw, scroll and clear commands,
//   one per cycle unless stalled, with cmd.last set on the final command caused by an item.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 sets
//   text_columns, index 1 text_rows; cfg_ready is always high. Write only idle.
// Timing:
//   The front end takes one item every cycle while the queue is not full and turns it into a
//   bundle of up to four commands in that same cycle. A four-entry bundle queue sits between it
//   and the sequencer; with an idle output the bundle passes through the queue and then the
//   sequencer's bundle register before cmd_valid rises. The sequencer drains one command per
//   cycle unless stalled, back to back across items, so the input keeps one item per cycle as
//   long as items average one command; commandless items (escape bytes, CR, NUL) skip the queue.
// Reset: asynchronous, rst_n low. Cursor homes, colors go white on black, the
//   parser is idle, geometry returns to 80 x 25 and the queue empties.
// A stalled cmd holds its payload; the queue absorbs bursts until full.
module ansi_text_console_stream_core
    import atcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,
    output logic                 cmd_valid,
    input  logic                 cmd_stall,
    output result_t              cmd,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [9:0]           cfg_data
);

    geom_t   geom_reg;
    logic    push, pop, q_empty, q_full;
    bundle_t push_data, head_data;

    // geometry registers, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            geom_reg.cols <= COLS_RESET;
            geom_reg.rows <= ROWS_RESET;
        end
        else if (cfg_valid) begin
            if (cfg_index == REG_TEXT_COLUMNS)
                geom_reg.cols <= cfg_data;
            else if (cfg_index == REG_TEXT_ROWS)
                geom_reg.rows <= cfg_data;
        end
    end

    // parser and cursor tracker
    atcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .geom       (geom_reg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .push       (push),
        .bundle     (push_data)
    );

    // decouples parsing from command playout
    atcs_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_data),
        .pop   (pop),
        .rdata (head_data),
        .empty (q_empty),
        .full  (q_full)
    );

    // one command per cycle toward the renderer while cmd_stall is low
    atcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (head_data),
        .pop       (pop),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd)
    );

endmodule

### test/atcs_console_checker.sv
// Checker for the ANSI text console core: predicts commands from accepted items and compares.
module atcs_console_checker
    import atcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_stall,
    input  item_t                item,
    input  logic                 cmd_valid,
    input  logic                 cmd_stall,
    input  result_t              cmd,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [9:0]           cfg_data,
    output int                   mismatches,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // palette channel levels: normal on, bright on, bright off, normal off
    localparam logic [7:0] LEVEL_HIGH = 8'hAA;
    localparam logic [7:0] LEVEL_FULL = 8'hFF;
    localparam logic [7:0] LEVEL_LOW  = 8'h55;
    localparam logic [7:0] LEVEL_NONE = 8'h00;

    logic [9:0]  geom_cols;
    logic [9:0]  geom_rows;
    logic [9:0]  cur_col;
    logic [9:0]  cur_row;
    logic        esc_pending;
    logic        in_sgr;
    logic [3:0]  field_idx;
    logic [15:0] sgr_cmd;
    logic [15:0] sgr_arg [ARG_SLOTS];
    logic [23:0] fg;
    logic [23:0] bg;

    result_t expected_cmds[$];
    int      fails;

    function automatic void reset_console();
        geom_cols   = COLS_RESET;
        geom_rows   = ROWS_RESET;
        cur_col     = '0;
        cur_row     = '0;
        esc_pending = 1'b0;
        in_sgr      = 1'b0;
        field_idx   = '0;
        sgr_cmd     = '0;
        foreach (sgr_arg[k])
            sgr_arg[k] = '0;
        fg          = FG_RESET;
        bg          = BG_RESET;
    endfunction

    function automatic void push_cmd(logic [1:0] kind, logic [9:0] col, logic [9:0] row,
                                     logic [7:0] glyph, logic [23:0] fill);
        result_t r;
        r.command_kind = kind;
        r.text_col     = col;
        r.text_row     = row;
        r.glyph_code   = glyph;
        r.fg_color     = fg;
        r.bg_color     = fill;
        r.last         = 1'b0;
        expected_cmds.push_back(r);
    endfunction

    function automatic void advance_line();
        cur_col = '0;
        cur_row = cur_row + 10'd1;
        if (cur_row >= geom_rows)
        begin
            push_cmd(CMD_SCROLL, '0, '0, '0, bg);
            cur_row = (geom_rows == '0) ? '0 : geom_rows - 10'd1;
        end
    endfunction

    function automatic void put_glyph(logic [7:0] g);
        push_cmd(CMD_DRAW, cur_col, cur_row, g, bg);
        cur_col = cur_col + 10'd1;
        if (cur_col >= geom_cols)
            advance_line();
    endfunction

    function automatic void text_byte(logic [7:0] c);
        if (c == CH_LF)
            advance_line();
        else if (c == CH_CR)
            cur_col = '0;
        else if (c == CH_ESC)
            esc_pending = 1'b1;
        else if (c != CH_NUL)
            put_glyph(c);
    endfunction

    // 16-entry palette: bit 0 red, bit 1 green, bit 2 blue, bit 3 bright
    function automatic logic [23:0] palette_color(logic [3:0] idx);
        logic [7:0] lit;
        logic [7:0] dark;
        lit  = idx[3] ? LEVEL_FULL : LEVEL_HIGH;
        dark = idx[3] ? LEVEL_LOW : LEVEL_NONE;
        return {idx[0] ? lit : dark, idx[1] ? lit : dark, idx[2] ? lit : dark};
    endfunction

    function automatic void finish_sgr();
        logic [23:0] color;
        in_sgr = 1'b0;
        if (sgr_arg[0] == SEL_PALETTE)
            color = palette_color(sgr_arg[1][3:0]);
        else if (sgr_arg[0] == SEL_DIRECT)
            color = {sgr_arg[1][7:0], sgr_arg[2][7:0], sgr_arg[3][7:0]};
        else
            return;
        if (sgr_cmd == SGR_FG)
            fg = color;
        else if (sgr_cmd == SGR_BG)
            bg = color;
    endfunction

    function automatic void sgr_byte(logic [7:0] c);
        logic [15:0] d;
        d = {8'd0, c - CH_ZERO};
        if (c == CH_SEMI)
        begin
            if (field_idx != POS_MAX)
                field_idx = field_idx + 4'd1;
        end
        else if (c == CH_SGR)
            finish_sgr();
        else if (c >= CH_ZERO && c <= CH_NINE)
        begin
            if (field_idx == '0)
                sgr_cmd = sgr_cmd * 16'd10 + d;
            else if (field_idx <= ARG_SLOTS)
                sgr_arg[field_idx - 1] = sgr_arg[field_idx - 1] * 16'd10 + d;
        end
    endfunction

    function automatic void predict_commands(item_t in_item);
        int      base;
        result_t r;
        base = expected_cmds.size();
        if (in_item.action == ACT_CLEAR)
        begin
            esc_pending = 1'b0;
            in_sgr      = 1'b0;
            cur_col     = '0;
            cur_row     = '0;
            push_cmd(CMD_CLEAR, '0, '0, '0, in_item.clear_color);
        end
        else if (in_sgr)
            sgr_byte(in_item.char_code);
        else if (esc_pending)
        begin
            esc_pending = 1'b0;
            if (in_item.char_code == CH_LBRK)
            begin
                in_sgr    = 1'b1;
                field_idx = '0;
                sgr_cmd   = '0;
                foreach (sgr_arg[k])
                    sgr_arg[k] = '0;
            end
            else
            begin
                put_glyph(CH_ESC);
                text_byte(in_item.char_code);
            end
        end
        else
            text_byte(in_item.char_code);
        if (expected_cmds.size() > base)
        begin
            r = expected_cmds.pop_back();
            r.last = 1'b1;
            expected_cmds.push_back(r);
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    function automatic void check_cmd(result_t got);
        result_t want;
        if (expected_cmds.size() == 0)
        begin
            fails++;
            $display("%0t: command with none expected, expected nothing, actual %h", $time, got);
            return;
        end
        want = expected_cmds.pop_front();
        check_field("command_kind", want.command_kind, got.command_kind);
        check_field("text_col", want.text_col, got.text_col);
        check_field("text_row", want.text_row, got.text_row);
        check_field("glyph_code", want.glyph_code, got.glyph_code);
        check_field("fg_color", want.fg_color, got.fg_color);
        check_field("bg_color", want.bg_color, got.bg_color);
        check_field("last", want.last, got.last);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_console();
            expected_cmds.delete();
            fails = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TEXT_COLUMNS)
                    geom_cols = cfg_data;
                else if (cfg_index == REG_TEXT_ROWS)
                    geom_rows = cfg_data;
            end
            if (item_valid && !item_stall)
                predict_commands(item);
            if (cmd_valid && !cmd_stall)
                check_cmd(cmd);
            mismatches <= fails;
            pending    <= expected_cmds.size();
        end
    end

endmodule

### test/ansi_text_console_stream_core_test.sv
// Top of the console core testbench: clock, reset, item and command traffic, geometry phases.
module ansi_text_console_stream_core_test
    import atcs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_MAX       = 12;    // longest gap / stall drawn per item
    localparam int SETTLE_CYCLES  = 8;     // margin for the pipeline to settle before cfg
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no handshake at all
    localparam int PHASES         = 9;
    localparam int PHASE_ITEMS    = 34;    // random items per geometry phase

    // index with no register behind it; a write must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    item_t                item;
    logic                 cmd_valid;
    logic                 cmd_stall;
    result_t              cmd;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [9:0]           cfg_data;

    int mismatches;
    int pending;

    // when set, neither side idles: back-to-back items and no output stall
    bit steady;
    int sent_count;
    int noise_count;
    int idle_cycles;

    ansi_text_console_stream_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    atcs_console_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one item after a random gap and hold it until accepted. Valid is
    // left high on return so a zero gap on the next item keeps it asserted.
    task automatic send_item(input item_t next);
        int gap;
        gap = steady ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= next;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sent_count++;
    endtask

    // unused payload fields carry random bits so every input bit toggles
    task automatic send_char(input logic [7:0] c);
        item_t x;
        x.action      = ACT_CHAR;
        x.char_code   = c;
        x.clear_color = 24'($urandom);
        send_item(x);
    endtask

    task automatic send_clear(input logic [23:0] color);
        item_t x;
        x.action      = ACT_CLEAR;
        x.char_code   = 8'($urandom);
        x.clear_color = color;
        send_item(x);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_number(input int unsigned v);
        send_text($sformatf("%0d", v));
    endtask

    // Hold off the sender until every expected command has drained, then let
    // the pipeline settle; items that make no command leave nothing pending.
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // cfg_valid stays high between back-to-back writes; caller lowers it
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [9:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_geometry(input logic [9:0] cols, input logic [9:0] rows,
                                input bit spare);
        cfg_put(REG_TEXT_COLUMNS, cols);
        cfg_put(REG_TEXT_ROWS, rows);
        if (spare)
            cfg_put(REG_SPARE, 10'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // mostly small values; some past 8 bits to hit the palette/component
    // masks, a few past 16 bits to wrap the accumulators
    function automatic int unsigned pick_arg();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return $urandom_range(0, 20);
        else if (roll < 9)
            return $urandom_range(0, 1020);
        return $urandom_range(0, 999999);
    endfunction

    // a byte the parser skips inside a sequence (not a digit, ';' or 'm')
    task automatic maybe_noise();
        logic [7:0] c;
        if ($urandom_range(0, 5) == 0)
        begin
            do
                c = 8'($urandom);
            while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_SEMI || c == CH_SGR);
            send_char(c);
            noise_count++;
        end
    endtask

    // ESC [ cmd ; sel ; args m, mostly well formed with random content; some
    // have odd commands or selectors, empty fields, long ';' runs that
    // saturate the position, or end in a clear or not at all
    task automatic send_sgr();
        int unsigned sel;
        int          nargs;
        int          roll;
        send_char(CH_ESC);
        send_char(CH_LBRK);
        roll = $urandom_range(0, 9);
        if (roll < 4)
            send_number(SGR_FG);
        else if (roll < 8)
            send_number(SGR_BG);
        else if (roll < 9)
            send_number(pick_arg());
        maybe_noise();
        roll = $urandom_range(0, 9);
        if (roll < 5)
            sel = SEL_PALETTE;
        else if (roll < 9)
            sel = SEL_DIRECT;
        else
            sel = pick_arg();
        send_char(CH_SEMI);
        send_number(sel);
        if (sel == SEL_PALETTE)
            nargs = 1;
        else if (sel == SEL_DIRECT)
            nargs = 3;
        else
            nargs = $urandom_range(0, 4);
        if ($urandom_range(0, 7) == 0)
            nargs += $urandom_range(1, 16);
        for (int k = 0; k < nargs; k++)
        begin
            send_char(CH_SEMI);
            maybe_noise();
            if ($urandom_range(0, 9) != 0)
                send_number(pick_arg());
        end
        roll = $urandom_range(0, 19);
        if (roll == 0)
            send_clear(24'($urandom));
        else if (roll != 1)
            send_char(CH_SGR);
    endtask

    task automatic send_text_run();
        int len;
        int roll;
        len = $urandom_range(1, 12);
        repeat (len)
        begin
            roll = $urandom_range(0, 19);
            if (roll < 13)
                send_char(8'($urandom_range(8'h20, 8'h7E)));
            else if (roll < 15)
                send_char(8'($urandom_range(8'h80, 8'hFF)));
            else if (roll == 15)
                send_char(CH_LF);
            else if (roll == 16)
                send_char(CH_CR);
            else if (roll == 17)
                send_char(CH_NUL);
            else
                send_char(8'($urandom_range(1, 8'h1F)));
        end
    endtask

    // ESC followed by anything but '[': ESC is drawn, then the byte as usual
    task automatic send_broken_escape();
        logic [7:0] c;
        int         roll;
        roll = $urandom_range(0, 4);
        if (roll == 0)
            c = CH_ESC;
        else if (roll == 1)
            c = CH_LF;
        else if (roll == 2)
            c = CH_CR;
        else if (roll == 3)
            c = CH_NUL;
        else
        begin
            c = 8'($urandom);
            if (c == CH_LBRK)
                c = "x";
        end
        send_char(CH_ESC);
        send_char(c);
    endtask

    task automatic send_chunk();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            send_sgr();
        else if (pick < 78)
            send_text_run();
        else if (pick < 88)
            send_broken_escape();
        else if (pick < 94)
            send_clear(24'($urandom));
        else
            send_char(8'($urandom));
    endtask

    // Command side: a random stall before each command, released until the
    // next one is taken. One assignment to cmd_stall per time step.
    initial
    begin
        int hold;
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, IDLE_MAX);
            if (hold > 0)
            begin
                cmd_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            cmd_stall <= 1'b0;
            @(posedge clk);
            while (!cmd_valid)
                @(posedge clk);
        end
    end

    // Watchdog: any handshake restarts the count.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (cmd_valid && !cmd_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int target;
        rst_n       <= 1'b0;
        item_valid  <= 1'b0;
        item        <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_TEXT_COLUMNS;
        cfg_data    <= '0;
        steady      = 1'b0;
        sent_count  = 0;
        noise_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset geometry: clear extremes, glyph byte
        // extremes, ignored NUL, CR, LF, ESC not followed by '[', and a
        // palette foreground sequence followed by a glyph in the new color.
        send_clear(24'hFFFFFF);
        send_char("A");
        send_char(8'hFF);
        send_char(CH_NUL);
        send_char(CH_CR);
        send_char(CH_LF);
        send_char(CH_ESC);
        send_char("x");
        send_char(CH_ESC);
        send_text("[38;5;9m");
        send_char("B");
        send_clear(24'h000000);
        drain();

        // Random part, one geometry per phase. Phase 0 keeps the reset size;
        // the next one shrinks it so the cursor starts past the new bounds.
        // Zero sizes wrap after every glyph / scroll on every new line, and
        // a one-by-one screen lets one item give the most commands.
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 1)
                set_geometry(10'd7, 10'd3, 1'b0);
            else if (p == 2)
                set_geometry(10'd1023, 10'd1023, 1'b0);
            else if (p == 3)
                set_geometry(10'd1, 10'd1, 1'b0);
            else if (p == 4)
                set_geometry(10'd0, 10'd1023, 1'b0);
            else if (p == 5)
                set_geometry(10'd1023, 10'd0, 1'b1);
            else if (p == 6)
                set_geometry(10'($urandom_range(1, 16)), 10'($urandom_range(1, 8)), 1'b0);
            else if (p == 7)
                set_geometry(10'd0, 10'd0, 1'b0);
            else if (p == 8)
                set_geometry(COLS_RESET, ROWS_RESET, 1'b0);
            steady = ($urandom_range(0, 2) == 0);
            target = sent_count - noise_count + PHASE_ITEMS;
            while (sent_count - noise_count < target)
            begin
                send_chunk();
                if ($urandom_range(0, 14) == 0)
                    steady = !steady;
                // occasionally let the output side run dry mid-phase
                if ($urandom_range(0, 39) == 0)
                    drain();
            end
            drain();
        end

        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
design/atcs_pkg.sv
design/atcs_front.sv
design/atcs_queue.sv
design/atcs_back.sv
design/ansi_text_console_stream_core.sv
test/atcs_console_checker.sv
test/ansi_text_console_stream_core_test.sv
